FILE: design/bms_pkg.sv
// shared types, command codes and note tables for the buzzer melody sequencer
package bms_pkg;

  typedef struct packed {
    logic [1:0] cmd;
    logic [4:0] entry_index;
    logic [3:0] entry_note;
    logic [3:0] entry_beat;
  } in_item_t;

  typedef struct packed {
    logic       buzzer_level;
    logic [5:0] melody_position;
    logic       playing;
  } out_item_t;

  localparam logic [1:0] CMD_TICK  = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_START = 2'd2;

  localparam int NOTE_COUNT = 14;
  localparam int TUNE_LEN   = 32;

  localparam logic [3:0] NOTE_LOW     = 4'd1;
  localparam logic [3:0] NOTE_HIGH    = 4'd14;
  localparam logic [3:0] NOTE_INVALID = 4'd15;
  localparam logic [3:0] FILL_NOTE    = 4'd1;
  localparam logic [3:0] FILL_BEAT    = 4'd4;
  localparam logic [5:0] LENGTH_RESET = 6'd32;
  localparam logic [23:0] TIMER_RESET = 24'h00FF00;

  // tone frequency in hz
  localparam logic [10:0] NOTE_FREQ [NOTE_COUNT] = '{
    11'd523, 11'd587, 11'd659, 11'd698, 11'd784, 11'd880, 11'd988,
    11'd1047, 11'd1175, 11'd1319, 11'd1397, 11'd1568, 11'd1760, 11'd1976
  };

  // machine-clock ticks per half period: (11059200/12) / (2 * freq)
  localparam logic [9:0] HALF_PERIOD [NOTE_COUNT] = '{
    10'd881, 10'd785, 10'd699, 10'd660, 10'd587, 10'd523, 10'd466,
    10'd440, 10'd392, 10'd349, 10'd329, 10'd293, 10'd261, 10'd233
  };

  localparam logic [3:0] TUNE_NOTES [TUNE_LEN] = '{
    4'd1, 4'd2, 4'd3, 4'd1, 4'd1, 4'd2, 4'd3, 4'd1,
    4'd3, 4'd4, 4'd5, 4'd3, 4'd4, 4'd5, 4'd5, 4'd6,
    4'd5, 4'd4, 4'd3, 4'd1, 4'd5, 4'd6, 4'd5, 4'd4,
    4'd3, 4'd1, 4'd1, 4'd5, 4'd1, 4'd1, 4'd5, 4'd1
  };

  localparam logic [3:0] TUNE_BEATS [TUNE_LEN] = '{
    4'd4, 4'd4, 4'd4, 4'd4, 4'd4, 4'd4, 4'd4, 4'd4,
    4'd4, 4'd4, 4'd8, 4'd4, 4'd4, 4'd8, 4'd3, 4'd1,
    4'd3, 4'd1, 4'd4, 4'd4, 4'd3, 4'd1, 4'd3, 4'd1,
    4'd4, 4'd4, 4'd4, 4'd4, 4'd8, 4'd4, 4'd4, 4'd8
  };

endpackage

FILE: design/buzzer_melody_sequencer.sv
// buzzer melody sequencer: tick timer, note sequencer and melody entry store
//
// input channel (in_valid, in_stall, in_data) carries one command per transfer:
// a timer tick, a melody entry write or a playback start. every input transfer
// produces exactly one output transfer (out_valid, out_stall, out_data) with
// the buzzer pin level, the entry now playing and the playing flag.
// an item is held in the input register, then the state update is done
// combinationally and the state registers act as the result register;
// out_valid is registered when the item leaves the input register.
// throughput is one item per cycle while out_stall is low.
// when out_stall is high the pending result holds, one more item is buffered
// in the input register and then in_stall rises until the result is taken.
// cfg_write_en/cfg_write_data set the melody length and may only be written
// while no item is pending.
// synchronous reset loads the built-in tune, length 32, timer and reload
// 0xff00, buzzer high, tone on and the sequencer stopped; no clearing pass.
module buzzer_melody_sequencer #(
  parameter int MELODY_DEPTH = 32,
  parameter int TIMER_BITS   = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  bms_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output bms_pkg::out_item_t  out_data,
  input  logic                cfg_write_en,
  input  logic [5:0]          cfg_write_data
);

  localparam int STORE     = (MELODY_DEPTH < bms_pkg::TUNE_LEN) ? MELODY_DEPTH
                                                                : bms_pkg::TUNE_LEN;
  localparam int IDX_W     = (STORE > 1) ? $clog2(STORE) : 1;
  localparam int DEPTH_CAP = (MELODY_DEPTH < 63) ? MELODY_DEPTH : 63;

  logic                  in_reg_valid;
  bms_pkg::in_item_t     in_reg;
  logic                  advance;
  logic                  accept;

  logic [5:0]            melody_length;
  logic [TIMER_BITS-1:0] timer_count, timer_count_next;
  logic [TIMER_BITS-1:0] reload_value, reload_value_next;
  logic [3:0]            melody_notes [STORE];
  logic [3:0]            melody_beats [STORE];
  logic [5:0]            position, position_next;
  logic [15:0]           note_elapsed, note_elapsed_next;
  logic [15:0]           note_total, note_total_next;
  logic [15:0]           sound_total, sound_total_next;
  logic                  tone_enable, tone_enable_next;
  logic                  buzzer_state, buzzer_state_next;
  logic                  active, active_next;

  logic [5:0]            len;
  logic                  entry_write;
  logic [3:0]            rd_note, rd_beat, code;
  logic [3:0]            note_sel;
  logic [10:0]           freq;
  logic [14:0]           beat_freq;
  logic [15:0]           total_calc;
  logic [23:0]           neg_half;
  logic [5:0]            position_inc;
  logic [15:0]           elapsed_inc;

  assign advance  = in_reg_valid && (!out_valid || !out_stall);
  assign in_stall = in_reg_valid && !advance;
  assign accept   = in_valid && !in_stall;

  assign len = (32'(melody_length) < 32'(DEPTH_CAP)) ? melody_length : 6'(DEPTH_CAP);

  assign entry_write = advance && (in_reg.cmd == bms_pkg::CMD_WRITE) &&
                       (32'(in_reg.entry_index) < 32'(STORE));

  // entry lookup at the playing position
  always_comb begin
    if (32'(position) < 32'(STORE)) begin
      rd_note = melody_notes[position[IDX_W-1:0]];
      rd_beat = melody_beats[position[IDX_W-1:0]];
    end else begin
      rd_note = bms_pkg::FILL_NOTE;
      rd_beat = bms_pkg::FILL_BEAT;
    end
    code = rd_note;
    if (code < bms_pkg::NOTE_LOW) begin
      code = bms_pkg::NOTE_LOW;
    end
    if (code == bms_pkg::NOTE_INVALID) begin
      code = bms_pkg::NOTE_HIGH;
    end
    note_sel   = code - 4'd1;
    freq       = bms_pkg::NOTE_FREQ[note_sel];
    beat_freq  = 15'(rd_beat) * freq;
    total_calc = 16'(beat_freq >> 2);
    neg_half   = 24'd0 - 24'(bms_pkg::HALF_PERIOD[note_sel]);
  end

  assign position_inc = position + 6'd1;
  assign elapsed_inc  = note_elapsed + 16'd1;

  always_comb begin
    timer_count_next  = timer_count;
    reload_value_next = reload_value;
    position_next     = position;
    note_elapsed_next = note_elapsed;
    note_total_next   = note_total;
    sound_total_next  = sound_total;
    tone_enable_next  = tone_enable;
    buzzer_state_next = buzzer_state;
    active_next       = active;
    if (advance) begin
      unique case (in_reg.cmd)
        bms_pkg::CMD_TICK: begin
          timer_count_next = timer_count + TIMER_BITS'(1);
          if (timer_count == '1) begin
            timer_count_next  = reload_value;
            buzzer_state_next = tone_enable ? !buzzer_state : 1'b1;
            if (active) begin
              if (position >= len) begin
                active_next = 1'b0;
              end else if (note_elapsed == 16'd0) begin
                reload_value_next = neg_half[TIMER_BITS-1:0];
                note_total_next   = total_calc;
                sound_total_next  = total_calc - (total_calc >> 2);
                tone_enable_next  = 1'b1;
                note_elapsed_next = 16'd1;
              end else if (note_elapsed >= note_total) begin
                note_elapsed_next = 16'd0;
                position_next     = position_inc;
                if (position_inc >= len) begin
                  active_next = 1'b0;
                end
              end else begin
                note_elapsed_next = elapsed_inc;
                if (elapsed_inc == sound_total) begin
                  tone_enable_next = 1'b0;
                end
              end
            end
          end
        end
        bms_pkg::CMD_START: begin
          position_next     = 6'd0;
          note_elapsed_next = 16'd0;
          active_next       = (len != 6'd0);
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_reg_valid <= 1'b0;
    end else if (accept) begin
      in_reg_valid <= 1'b1;
    end else if (advance) begin
      in_reg_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_reg <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      melody_length <= bms_pkg::LENGTH_RESET;
    end else if (cfg_write_en) begin
      melody_length <= cfg_write_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < STORE; i++) begin
        melody_notes[i] <= bms_pkg::TUNE_NOTES[i];
        melody_beats[i] <= bms_pkg::TUNE_BEATS[i];
      end
    end else if (entry_write) begin
      melody_notes[in_reg.entry_index[IDX_W-1:0]] <= in_reg.entry_note;
      melody_beats[in_reg.entry_index[IDX_W-1:0]] <= in_reg.entry_beat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      timer_count  <= bms_pkg::TIMER_RESET[TIMER_BITS-1:0];
      reload_value <= bms_pkg::TIMER_RESET[TIMER_BITS-1:0];
      position     <= 6'd0;
      note_elapsed <= 16'd0;
      note_total   <= 16'd0;
      sound_total  <= 16'd0;
      tone_enable  <= 1'b1;
      buzzer_state <= 1'b1;
      active       <= 1'b0;
    end else begin
      timer_count  <= timer_count_next;
      reload_value <= reload_value_next;
      position     <= position_next;
      note_elapsed <= note_elapsed_next;
      note_total   <= note_total_next;
      sound_total  <= sound_total_next;
      tone_enable  <= tone_enable_next;
      buzzer_state <= buzzer_state_next;
      active       <= active_next;
    end
  end

  assign out_data.buzzer_level    = buzzer_state;
  assign out_data.melody_position = position;
  assign out_data.playing         = active;

  a_stall_needs_item: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> in_reg_valid)
    else $error("input stalled with empty input register");

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    advance |=> out_valid)
    else $error("processed item gave no result");

  a_silent_high: assert property (@(posedge clk) disable iff (rst)
    advance && (in_reg.cmd == bms_pkg::CMD_TICK) && (timer_count == '1) && !tone_enable
    |=> buzzer_state)
    else $error("buzzer not held high while tone is off");

  a_start_clears: assert property (@(posedge clk) disable iff (rst)
    advance && (in_reg.cmd == bms_pkg::CMD_START)
    |=> (position == 6'd0) && (note_elapsed == 16'd0))
    else $error("start did not rewind the sequencer");

  a_sound_in_note: assert property (@(posedge clk) disable iff (rst)
    sound_total <= note_total)
    else $error("sound time exceeds note time");

endmodule

FILE: verif/bms_checker.sv
`timescale 1ns / 1ps
// checker for the buzzer melody sequencer: predicts each result and compares it with the output
module bms_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_stall,
  input  bms_pkg::in_item_t  in_data,
  input  logic               out_valid,
  input  logic               out_stall,
  input  bms_pkg::out_item_t out_data,
  input  logic               cfg_write_en,
  input  logic [5:0]         cfg_write_data,
  output int                 mismatches,
  output int                 outstanding
);

  localparam int ENTRIES = 32;
  localparam int unsigned MACHINE_HZ = 11059200 / 12;

  localparam int unsigned TONE_HZ [14] = '{
    523, 587, 659, 698, 784, 880, 988,
    1047, 1175, 1319, 1397, 1568, 1760, 1976
  };

  localparam logic [3:0] SONG_NOTES [ENTRIES] = '{
    4'd1, 4'd2, 4'd3, 4'd1, 4'd1, 4'd2, 4'd3, 4'd1,
    4'd3, 4'd4, 4'd5, 4'd3, 4'd4, 4'd5, 4'd5, 4'd6,
    4'd5, 4'd4, 4'd3, 4'd1, 4'd5, 4'd6, 4'd5, 4'd4,
    4'd3, 4'd1, 4'd1, 4'd5, 4'd1, 4'd1, 4'd5, 4'd1
  };

  localparam logic [3:0] SONG_BEATS [ENTRIES] = '{
    4'd4, 4'd4, 4'd4, 4'd4, 4'd4, 4'd4, 4'd4, 4'd4,
    4'd4, 4'd4, 4'd8, 4'd4, 4'd4, 4'd8, 4'd3, 4'd1,
    4'd3, 4'd1, 4'd4, 4'd4, 4'd3, 4'd1, 4'd3, 4'd1,
    4'd4, 4'd4, 4'd4, 4'd4, 4'd8, 4'd4, 4'd4, 4'd8
  };

  logic [5:0]          song_len;
  logic [15:0]         timer;
  logic [15:0]         reload;
  logic [3:0]          notes [ENTRIES];
  logic [3:0]          beats [ENTRIES];
  logic [5:0]          pos;
  logic [15:0]         elapsed;
  logic [15:0]         note_len;
  logic [15:0]         sound_len;
  logic                tone_on;
  logic                pin;
  logic                running;
  bms_pkg::out_item_t  pending_results [$];
  bms_pkg::out_item_t  want;
  int                  fail_count = 0;

  assign mismatches = fail_count;

  function automatic logic [5:0] play_len();
    return (song_len < ENTRIES) ? song_len : 6'(ENTRIES);
  endfunction

  task automatic power_on();
    song_len = bms_pkg::LENGTH_RESET;
    timer = 16'hFF00;
    reload = 16'hFF00;
    for (int i = 0; i < ENTRIES; i++) begin
      notes[i] = SONG_NOTES[i];
      beats[i] = SONG_BEATS[i];
    end
    pos = '0;
    elapsed = '0;
    note_len = '0;
    sound_len = '0;
    tone_on = 1'b1;
    pin = 1'b1;
    running = 1'b0;
  endtask

  task automatic melody_step();
    int unsigned hz;
    logic [3:0] code;
    if (!running) return;
    if (pos >= play_len()) begin
      running = 1'b0;
      return;
    end
    if (elapsed == 16'd0) begin
      code = notes[pos[4:0]];
      if (code == 4'd0) code = 4'd1;
      else if (code == 4'd15) code = 4'd14;
      hz = TONE_HZ[code - 4'd1];
      reload = 16'(32'h10000 - MACHINE_HZ / (2 * hz));
      note_len = 16'((32'(beats[pos[4:0]]) * hz) >> 2);
      sound_len = note_len - (note_len >> 2);
      tone_on = 1'b1;
      elapsed = 16'd1;
    end else if (elapsed >= note_len) begin
      elapsed = 16'd0;
      pos = pos + 6'd1;
      if (pos >= play_len()) running = 1'b0;
    end else begin
      elapsed = elapsed + 16'd1;
      if (elapsed == sound_len) tone_on = 1'b0;
    end
  endtask

  task automatic apply_command(bms_pkg::in_item_t it);
    case (it.cmd)
      bms_pkg::CMD_TICK: begin
        timer = timer + 16'd1;
        if (timer == 16'd0) begin
          timer = reload;
          pin = tone_on ? ~pin : 1'b1;
          melody_step();
        end
      end
      bms_pkg::CMD_WRITE: begin
        notes[it.entry_index] = it.entry_note;
        beats[it.entry_index] = it.entry_beat;
      end
      bms_pkg::CMD_START: begin
        pos = '0;
        elapsed = '0;
        running = (play_len() != 6'd0);
      end
      default: ;
    endcase
    pending_results.push_back('{buzzer_level: pin, melody_position: pos, playing: running});
  endtask

  task automatic report_mismatch(string msg);
    $display("%0t mismatch: %s", $time, msg);
    fail_count++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      power_on();
      pending_results.delete();
    end else begin
      if (cfg_write_en) song_len = cfg_write_data;
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          report_mismatch($sformatf("unexpected transfer buzzer %0b position %0d playing %0b",
                                    out_data.buzzer_level, out_data.melody_position,
                                    out_data.playing));
        end else begin
          want = pending_results.pop_front();
          if (out_data.buzzer_level !== want.buzzer_level)
            report_mismatch($sformatf("buzzer_level got %0b want %0b",
                                      out_data.buzzer_level, want.buzzer_level));
          if (out_data.melody_position !== want.melody_position)
            report_mismatch($sformatf("melody_position got %0d want %0d",
                                      out_data.melody_position, want.melody_position));
          if (out_data.playing !== want.playing)
            report_mismatch($sformatf("playing got %0b want %0b",
                                      out_data.playing, want.playing));
        end
      end
      if (in_valid && !in_stall) apply_command(in_data);
    end
    outstanding <= pending_results.size();
  end

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 1ps
// testbench top: drives commands and length writes into the buzzer melody sequencer
module tb_top;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int QUIET_LIMIT = 4000;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  bms_pkg::in_item_t  in_data = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  bms_pkg::out_item_t out_data;
  logic               cfg_write_en = 1'b0;
  logic [5:0]         cfg_write_data = '0;
  int                 mismatches;
  int                 outstanding;
  int                 send_idle = 0;
  int                 recv_idle = 0;
  int                 quiet = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  buzzer_melody_sequencer uut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_data       (out_data),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data)
  );

  bms_checker result_check (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_data       (out_data),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .mismatches     (mismatches),
    .outstanding    (outstanding)
  );

  always @(posedge clk) out_stall <= ($urandom_range(99) < recv_idle);

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet <= 0;
    else quiet <= quiet + 1;
  end

  initial begin
    while (quiet < QUIET_LIMIT) @(posedge clk);
    $display("FAIL buzzer_melody_sequencer");
    $finish;
  end

  function automatic bms_pkg::in_item_t any_fields(logic [1:0] cmd);
    bms_pkg::in_item_t it;
    it.cmd = cmd;
    it.entry_index = 5'($urandom_range(31));
    it.entry_note = 4'($urandom_range(15));
    it.entry_beat = 4'($urandom_range(15));
    return it;
  endfunction

  task automatic send(bms_pkg::in_item_t it);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic tick(int n);
    repeat (n) send(any_fields(bms_pkg::CMD_TICK));
  endtask

  task automatic write_entry(logic [4:0] idx, logic [3:0] note, logic [3:0] beat);
    bms_pkg::in_item_t it;
    it = any_fields(bms_pkg::CMD_WRITE);
    it.entry_index = idx;
    it.entry_note = note;
    it.entry_beat = beat;
    send(it);
  endtask

  task automatic start_play();
    send(any_fields(bms_pkg::CMD_START));
  endtask

  // hold off until every transfer sent has come back
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic set_length(logic [5:0] len);
    settle();
    cfg_write_en <= 1'b1;
    cfg_write_data <= len;
    @(posedge clk);
    cfg_write_en <= 1'b0;
  endtask

  function automatic logic [5:0] pick_length();
    case ($urandom_range(5))
      0: return 6'd0;
      1: return 6'd1;
      2: return 6'd32;
      3: return 6'd63;
      default: return 6'($urandom_range(1, 32));
    endcase
  endfunction

  task automatic play_round();
    int n;
    case ($urandom_range(9)) inside
      [0:5]: begin
        n = $urandom_range(1, 4);
        if ($urandom_range(1) == 1) set_length(6'(n));
        for (int i = 0; i < n; i++)
          write_entry(5'(i), 4'($urandom_range(15)),
                      ($urandom_range(4) == 0) ? 4'($urandom_range(15)) : 4'd0);
        start_play();
        tick($urandom_range(5, 30));
      end
      6: repeat ($urandom_range(1, 10)) send(any_fields(2'($urandom_range(3))));
      7: begin
        start_play();
        tick($urandom_range(5, 30));
      end
      8: begin
        write_entry(5'($urandom_range(31)), 4'($urandom_range(15)), 4'($urandom_range(15)));
        tick($urandom_range(5, 30));
      end
      default: set_length(pick_length());
    endcase
  endtask

  task automatic run_phase(int s_idle, int r_idle, int rounds);
    send_idle = s_idle;
    recv_idle = r_idle;
    repeat (rounds) play_round();
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    send(bms_pkg::in_item_t'{CMD_UNUSED, 5'h1f, 4'hf, 4'hf});
    tick(1);
    write_entry(5'd0, 4'd15, 4'd0);
    write_entry(5'd1, 4'd0, 4'd0);
    write_entry(5'd2, 4'd14, 4'd15);
    write_entry(5'd31, 4'd15, 4'd15);
    send(bms_pkg::in_item_t'{bms_pkg::CMD_TICK, 5'h00, 4'h0, 4'h0});

    // two short notes played to the end of the melody
    set_length(6'd2);
    start_play();
    tick(1000);
    set_length(6'd0);
    start_play();
    tick(20);
    set_length(6'd63);
    start_play();
    start_play();
    tick(300);
    write_entry(5'd2, 4'd7, 4'd0);
    set_length(6'd32);

    run_phase(21, 82, 8);
    run_phase(82, 21, 8);
    run_phase(0, 0, 8);

    settle();
    repeat (10) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("PASS buzzer_melody_sequencer");
    end else begin
      $display("FAIL buzzer_melody_sequencer");
    end
    $finish;
  end

endmodule
